// ----- design/sha1sh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types, constants and helper functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

   localparam int NUM_WORDS  = 5;
   localparam int ROUND_BITS = 7;

   localparam logic [31:0] IV_WORDS [0:NUM_WORDS-1] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [ROUND_BITS-1:0] LAST_ROUND = 7'd79;
   localparam logic [ROUND_BITS-1:0] ROUND_20   = 7'd20;
   localparam logic [ROUND_BITS-1:0] ROUND_40   = 7'd40;
   localparam logic [ROUND_BITS-1:0] ROUND_60   = 7'd60;

   localparam logic [5:0] FILL_LAST   = 6'd63;
   localparam logic [5:0] LEN_ROOM    = 6'd55;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [2:0] LAST_INDEX  = 3'd4;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   typedef struct packed {
      logic shift_byte;
      logic shift_word;
   } sched_ctl_type;

   typedef struct packed {
      logic start;
      logic init_chain;
      logic rotate_chain;
   } round_ctl_type;

   typedef struct packed {
      logic round_active;
      logic done;
   } round_stat_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      rotl32 = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// ----- design/sha1sh_msg_sched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_msg_sched
// Block buffer and message schedule window. Bytes shift in while a block is
// collected; during the rounds the window advances one word per round.
// ----------------------------------------------------------------------------
module sha1sh_msg_sched (
   input  logic                   clock,
   input  sha1sh_pkg::sched_ctl_type ctl,
   input  logic [7:0]             byte_value,
   output logic [31:0]            w_word
);

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  w_next;

   assign w_word = win_ff[511:480];
   assign w_next = sha1sh_pkg::rotl32(win_ff[95:64] ^ win_ff[255:224] ^
                                      win_ff[447:416] ^ win_ff[511:480], 1);

   always_comb begin
      win_in = win_ff;
      if (ctl.shift_byte) begin
         win_in = {win_ff[503:0], byte_value};
      end else if (ctl.shift_word) begin
         win_in = {win_ff[479:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ----- design/sha1sh_round_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_round_unit
// SHA-1 round datapath. Runs 80 rounds, one per cycle, then folds the
// working variables into the chaining value.
// ----------------------------------------------------------------------------
module sha1sh_round_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  sha1sh_pkg::round_ctl_type  ctl,
   input  logic [31:0]                w_word,
   output sha1sh_pkg::round_stat_type stat,
   output logic [31:0]                chain_word
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] chain_ff [0:sha1sh_pkg::NUM_WORDS-1];
   logic [31:0] chain_in [0:sha1sh_pkg::NUM_WORDS-1];
   logic [sha1sh_pkg::ROUND_BITS-1:0] rnd_ff, rnd_in;
   logic        active_ff, active_in;
   logic        add_ff, add_in;
   logic        done_ff;
   logic [31:0] f_val, k_val, t_val;
   logic        last_round;

   assign last_round = (rnd_ff == sha1sh_pkg::LAST_ROUND);
   assign stat.round_active = active_ff;
   assign stat.done = done_ff;
   assign chain_word = chain_ff[0];

   always_comb begin
      if (rnd_ff < sha1sh_pkg::ROUND_20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1sh_pkg::K_0;
      end else if (rnd_ff < sha1sh_pkg::ROUND_40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K_1;
      end else if (rnd_ff < sha1sh_pkg::ROUND_60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1sh_pkg::K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K_3;
      end
      t_val = sha1sh_pkg::rotl32(a_ff, 5) + f_val + e_ff + w_word + k_val;
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctl.start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (active_ff) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = sha1sh_pkg::rotl32(b_ff, 30);
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      active_in = active_ff && !last_round;
      rnd_in    = rnd_ff;
      if (ctl.start) begin
         active_in = 1'b1;
         rnd_in    = '0;
      end else if (active_ff) begin
         rnd_in = rnd_ff + 1'b1;
      end
      add_in = active_ff && last_round;
   end

   always_comb begin
      for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++) begin
         chain_in[i] = chain_ff[i];
      end
      if (ctl.init_chain) begin
         for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++) begin
            chain_in[i] = sha1sh_pkg::IV_WORDS[i];
         end
      end else if (add_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end else if (ctl.rotate_chain) begin
         for (int i = 0; i < sha1sh_pkg::NUM_WORDS - 1; i++) begin
            chain_in[i] = chain_ff[i+1];
         end
         chain_in[sha1sh_pkg::NUM_WORDS-1] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         add_ff    <= 1'b0;
         done_ff   <= 1'b0;
         rnd_ff    <= '0;
         for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++) begin
            chain_ff[i] <= sha1sh_pkg::IV_WORDS[i];
         end
      end else begin
         active_ff <= active_in;
         add_ff    <= add_in;
         done_ff   <= add_ff;
         rnd_ff    <= rnd_in;
         for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

endmodule

// ----- design/sha1_stream_hasher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// SHA-1 over a byte stream with padding, length tracking and digest output.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one word per handshake: an optional message
// byte and an optional finish mark. A word is taken when req_valid is high
// and req_stall is low. After a byte word without a finish mark req_stall
// stays low, except after the 64th byte of a block, which starts the
// compression: req_stall then stays high while the round unit runs 80
// rounds, one per cycle, and adds the result into the chaining value.
// A finish word pads the message one byte per cycle through the block buffer,
// runs one or two compressions, and then presents the five digest words H0
// to H4 on the response channel, one per handshake, with rsp_last_word on
// H4. If the bit length overflowed, a single error word is sent instead.
// A finish word with n bytes pending passes through one setup state, 64 - n
// padding bytes and a compression before H0 is shown; a second padding
// block, needed past 55 pending bytes, adds its own padding and compression.
// While rsp_stall is high the current response word is held unchanged.
// After the last response word the block re-arms for a new message.
// Reset clears the length, fill count and overflow flag and loads the
// initial hash words; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_byte_present,
   input  logic        req_finish,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_length_error
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_COMP = 6'b000010,
      S_FIN  = 6'b000100,
      S_PAD  = 6'b001000,
      S_OUT  = 6'b010000,
      S_ERR  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        ovf_ff, ovf_in;
   logic        fin_pend_ff, fin_pend_in;
   logic        pad_mode_ff, pad_mode_in;
   logic        pad_first_ff, pad_first_in;
   logic        len_ok_ff, len_ok_in;
   logic        last_blk_ff, last_blk_in;
   logic [2:0]  idx_ff, idx_in;

   logic        wr_en;
   logic [7:0]  wr_byte;
   logic        rearm;
   logic [2:0]  len_sel;
   logic [7:0]  len_byte;
   logic [31:0] chain_word;

   sha1sh_pkg::sched_ctl_type  sctl;
   sha1sh_pkg::round_ctl_type  rctl;
   sha1sh_pkg::round_stat_type rstat;
   logic [31:0]                w_word;

   assign len_sel  = ~fill_ff[2:0];
   assign len_byte = bitlen_ff[{len_sel, 3'b000} +: 8];

   assign sctl.shift_byte = wr_en;
   assign sctl.shift_word = rstat.round_active;

   sha1sh_msg_sched u_sched (
      .clock      (clock),
      .ctl        (sctl),
      .byte_value (wr_byte),
      .w_word     (w_word)
   );

   sha1sh_round_unit u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rctl),
      .w_word     (w_word),
      .stat       (rstat),
      .chain_word (chain_word)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT) || (state_ff == S_ERR);
   assign rsp_digest_word  = (state_ff == S_OUT) ? chain_word : '0;
   assign rsp_word_index   = (state_ff == S_OUT) ? idx_ff : '0;
   assign rsp_last_word    = (state_ff == S_ERR) ||
                             (idx_ff == sha1sh_pkg::LAST_INDEX);
   assign rsp_length_error = (state_ff == S_ERR);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bitlen_in    = bitlen_ff;
      ovf_in       = ovf_ff;
      fin_pend_in  = fin_pend_ff;
      pad_mode_in  = pad_mode_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      last_blk_in  = last_blk_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_byte      = req_byte_value;
      rearm        = 1'b0;
      rctl         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fin_pend_in = req_finish;
               if (req_byte_present && !ovf_ff) begin
                  wr_en     = 1'b1;
                  bitlen_in = bitlen_ff + sha1sh_pkg::BYTE_BITS;
                  if (bitlen_in == '0) begin
                     ovf_in = 1'b1;
                  end
               end
               if (wr_en && (fill_ff == sha1sh_pkg::FILL_LAST)) begin
                  rctl.start = 1'b1;
                  state_in   = S_COMP;
               end else if (req_finish) begin
                  state_in = S_FIN;
               end
            end
         end
         S_COMP: begin
            if (rstat.done) begin
               if (pad_mode_ff) begin
                  state_in = last_blk_ff ? S_OUT : S_PAD;
               end else begin
                  state_in = fin_pend_ff ? S_FIN : S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (ovf_ff) begin
               state_in = S_ERR;
            end else begin
               state_in     = S_PAD;
               pad_mode_in  = 1'b1;
               pad_first_in = 1'b1;
               len_ok_in    = 1'b0;
               last_blk_in  = 1'b0;
            end
         end
         S_PAD: begin
            wr_en        = 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               wr_byte = sha1sh_pkg::PAD_BYTE;
            end else if (len_ok_ff && (fill_ff[5:3] == 3'b111)) begin
               wr_byte = len_byte;
            end else begin
               wr_byte = '0;
            end
            if (fill_ff == sha1sh_pkg::FILL_LAST) begin
               rctl.start = 1'b1;
               state_in   = S_COMP;
               if (len_ok_ff && !pad_first_ff) begin
                  last_blk_in = 1'b1;
               end else begin
                  len_ok_in = 1'b1;
               end
            end else if (pad_first_ff) begin
               len_ok_in = (fill_ff <= sha1sh_pkg::LEN_ROOM);
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rctl.rotate_chain = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == sha1sh_pkg::LAST_INDEX) begin
                  rearm = 1'b1;
               end
            end
         end
         S_ERR: begin
            if (!rsp_stall) begin
               rearm = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
      end

      if (rearm) begin
         state_in        = S_IDLE;
         fill_in         = '0;
         bitlen_in       = '0;
         ovf_in          = 1'b0;
         fin_pend_in     = 1'b0;
         pad_mode_in     = 1'b0;
         pad_first_in    = 1'b0;
         len_ok_in       = 1'b0;
         last_blk_in     = 1'b0;
         idx_in          = '0;
         rctl.init_chain = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         ovf_ff       <= 1'b0;
         fin_pend_ff  <= 1'b0;
         pad_mode_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         last_blk_ff  <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         ovf_ff       <= ovf_in;
         fin_pend_ff  <= fin_pend_in;
         pad_mode_ff  <= pad_mode_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
         last_blk_ff  <= last_blk_in;
         idx_ff       <= idx_in;
      end
   end

endmodule
